// ===== sv/vdr_pkg.sv =====
// Shared types and constants for the vertex dedup reindexer.
package vdr_pkg;

    localparam int WORD_W           = 64;
    localparam int MAX_WORDS        = 4;
    localparam int INDEX_W          = 10;
    localparam int COUNT_W          = 11;
    localparam int MAX_UNIQUE_DEF   = 1024;
    localparam int VERTEX_WORDS_DEF = 4;

    typedef struct packed {
        logic [WORD_W-1:0] vertex_word0;
        logic [WORD_W-1:0] vertex_word1;
        logic [WORD_W-1:0] vertex_word2;
        logic [WORD_W-1:0] vertex_word3;
        logic              last_corner;
    } in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] new_index;
        logic               is_new;
        logic               overflow;
        logic [COUNT_W-1:0] unique_count;
        logic               is_last;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic scan_empty;
        logic out_free;
    } status_t;

endpackage

// ===== sv/vertex_dedup_reindexer.sv =====
// Top level of the vertex dedup reindexer: controller plus datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_stall  | in_data: vertex words, last flag
//  out     | output    | out_valid/out_stall| out_data: index, flags, count
//
// Order: each request is compared against the unique vertices stored, slot by slot;
//   a hit ends the scan at its slot, and an empty table ends it with no reads. A new
//   request is accepted only after the last one commits, in the same cycle that its result shows.
// Reset: clears controller, fill count, scan pointer and result valid; a last request empties it.
// Stalls: in_stall is high from acceptance until the commit; a result waiting under
//   out_stall holds the next commit while the next request is accepted and scanned.
module vertex_dedup_reindexer
#(
    parameter int MAX_UNIQUE   = vdr_pkg::MAX_UNIQUE_DEF,
    parameter int VERTEX_WORDS = vdr_pkg::VERTEX_WORDS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  vdr_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output vdr_pkg::out_t out_data
);
    import vdr_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequences accept -> scan -> resolve for one request at a time
    vdr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // table memory, compare and result register
    vdr_datapath
    #(
        .MAX_UNIQUE   (MAX_UNIQUE),
        .VERTEX_WORDS (VERTEX_WORDS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== sv/vdr_ctrl.sv =====
// Request sequencing state machine for the vertex dedup reindexer.
module vdr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  vdr_pkg::status_t status,
    output vdr_pkg::cmd_t    cmd
);
    import vdr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_SCAN    = 3'b010,
        ST_RESOLVE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // stop reading once the table is exhausted or a match shows up
                if (status.hit || status.scan_empty)
                    state_next = ST_RESOLVE;
                else
                    cmd.scan = 1'b1;
            end
            ST_RESOLVE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/vdr_datapath.sv =====
// Unique-vertex table, scan pointer, compare and result register.
module vdr_datapath
#(
    parameter int MAX_UNIQUE   = vdr_pkg::MAX_UNIQUE_DEF,
    parameter int VERTEX_WORDS = vdr_pkg::VERTEX_WORDS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  vdr_pkg::in_t     in_data,
    input  vdr_pkg::cmd_t    cmd,
    output vdr_pkg::status_t status,
    output logic             out_valid,
    input  logic             out_stall,
    output vdr_pkg::out_t    out_data
);
    import vdr_pkg::*;

    localparam int IDX_W = $clog2(MAX_UNIQUE);
    localparam int CNT_W = $clog2(MAX_UNIQUE + 1);
    localparam int VTX_W = VERTEX_WORDS * WORD_W;

    logic [VTX_W-1:0]  mem [MAX_UNIQUE];

    logic [VTX_W-1:0]  vtx_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_slot_reg;
    logic [VTX_W-1:0]  rd_data_reg;
    logic              out_valid_reg;
    out_t              out_reg;

    logic [MAX_WORDS*WORD_W-1:0] in_all;
    logic              scan_more;
    logic              room;
    logic              do_write;
    logic [IDX_W-1:0]  slot;
    logic [CNT_W-1:0]  count_after;
    logic [IDX_W+INDEX_W-1:0] slot_ext;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign in_all = {in_data.vertex_word3, in_data.vertex_word2,
                     in_data.vertex_word1, in_data.vertex_word0};

    assign scan_more = (scan_idx_reg < count_reg);
    assign room      = (count_reg < CNT_W'(MAX_UNIQUE));

    assign status.hit        = rd_valid_reg && (rd_data_reg == vtx_reg);
    assign status.scan_empty = !scan_more && !rd_valid_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    // resolution of the request held in vtx_reg
    always_comb
    begin
        do_write    = 1'b0;
        slot        = '0;
        count_after = count_reg;
        if (status.hit)
        begin
            slot = rd_slot_reg;
        end
        else if (room)
        begin
            do_write    = 1'b1;
            slot        = count_reg[IDX_W-1:0];
            count_after = count_reg + CNT_W'(1);
        end
    end

    assign slot_ext  = {{INDEX_W{1'b0}}, slot};
    assign count_ext = {{COUNT_W{1'b0}}, count_after};

    // table memory: one read port for the scan, one write port for appends
    always_ff @(posedge clk)
    begin
        if (cmd.scan && scan_more)
            rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
        if (cmd.commit && do_write)
            mem[count_reg[IDX_W-1:0]] <= vtx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vtx_reg  <= in_all[VTX_W-1:0];
            last_reg <= in_data.last_corner;
        end
        if (cmd.scan && scan_more)
            rd_slot_reg <= scan_idx_reg[IDX_W-1:0];
        if (cmd.commit)
        begin
            out_reg.new_index    <= slot_ext[INDEX_W-1:0];
            out_reg.is_new       <= do_write;
            out_reg.overflow     <= !status.hit && !room;
            out_reg.unique_count <= count_ext[COUNT_W-1:0];
            out_reg.is_last      <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                rd_valid_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                rd_valid_reg <= scan_more;
                if (scan_more)
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end

            if (cmd.commit)
                count_reg <= last_reg ? '0 : count_after;

            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for vertex_dedup_reindexer: random handshakes against a scoreboard.
module tb;

    import vdr_pkg::*;

    localparam int VTX_W       = MAX_WORDS * WORD_W;
    localparam int HOLD_CYCLES = 300;   // long output back-pressure stretch
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = MAX_UNIQUE_DEF + 16;  // one full table scan plus slack
    localparam int RANDOM_CORNERS = 565;

    // One vertex record, word0 in the low bits.
    typedef logic [VTX_W-1:0] vertex_t;

    // Scoreboard: keeps its own copy of the unique-vertex table and the
    // reindex results that are still owed by the block.
    class dedup_scoreboard;
        vertex_t unique_vtx[$];
        out_t    reindex_q[$];
        int      errors;

        function int pending();
            return reindex_q.size();
        endfunction

        function void report(string what, out_t want, out_t got);
            errors++;
            if (errors <= 10)
                $display("%0t %s: want idx=%0d new=%0b ovf=%0b cnt=%0d last=%0b",
                         $time, what, want.new_index, want.is_new, want.overflow,
                         want.unique_count, want.is_last);
            if (errors <= 10)
                $display("%0t %s:  got idx=%0d new=%0b ovf=%0b cnt=%0d last=%0b",
                         $time, what, got.new_index, got.is_new, got.overflow,
                         got.unique_count, got.is_last);
        endfunction

        // Accepted corner: search, append or overflow, then clear on last.
        function void note_corner(in_t c);
            vertex_t vtx;
            out_t    want;
            int      hit_slot;
            vtx      = {c.vertex_word3, c.vertex_word2, c.vertex_word1, c.vertex_word0};
            hit_slot = -1;
            for (int i = 0; i < unique_vtx.size(); i++)
            begin
                if (unique_vtx[i] == vtx)
                begin
                    hit_slot = i;
                    break;
                end
            end
            want         = '0;
            want.is_last = c.last_corner;
            if (hit_slot >= 0)
                want.new_index = INDEX_W'(hit_slot);
            else if (unique_vtx.size() < MAX_UNIQUE_DEF)
            begin
                want.new_index = INDEX_W'(unique_vtx.size());
                want.is_new    = 1'b1;
                unique_vtx.push_back(vtx);
            end
            else
                want.overflow = 1'b1;
            want.unique_count = COUNT_W'(unique_vtx.size());
            if (c.last_corner)
                unique_vtx.delete();
            reindex_q.push_back(want);
        endfunction

        function void check_reindex(out_t got);
            out_t want;
            if (reindex_q.size() == 0)
            begin
                report("result with no corner pending", '0, got);
                return;
            end
            want = reindex_q.pop_front();
            if (got.new_index !== want.new_index || got.is_new !== want.is_new ||
                got.overflow !== want.overflow || got.unique_count !== want.unique_count ||
                got.is_last !== want.is_last)
                report("mismatch", want, got);
        endfunction
    endclass

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    in_t   in_data   = '0;
    logic  out_stall = 1'b0;
    logic  in_stall;
    logic  out_valid;
    out_t  out_data;

    dedup_scoreboard sb;
    bit    src_calm;      // sender stretch without gaps
    bit    sink_calm;     // receiver stretch without stalls
    int    corners_sent;

    vertex_dedup_reindexer u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop far beyond the slowest legal run (every corner a full
    // 1024-entry scan plus worst gaps on both sides).
    initial
    begin
        #100_000_000;
        $display("** vertex_dedup_reindexer: FAILED **");
        $finish;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic vertex_t rand_vertex();
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    // Offer one corner and wait for it to be taken. Valid stays high into
    // the next corner when no gap is drawn, so back-to-back requests work.
    task automatic send_corner(input vertex_t v, input bit last);
        in_t c;
        int  gap;
        c.vertex_word0 = v[0*WORD_W +: WORD_W];
        c.vertex_word1 = v[1*WORD_W +: WORD_W];
        c.vertex_word2 = v[2*WORD_W +: WORD_W];
        c.vertex_word3 = v[3*WORD_W +: WORD_W];
        c.last_corner  = last;
        gap = src_calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        // Values read right after the edge are the ones the block sampled.
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_corner(c);
        corners_sent++;
    endtask

    // One mesh built from a small vertex pool so that most corners hit.
    // Pool entries include all-zero/all-one records and near twins that
    // differ from another entry in a single bit. A few meshes are broken:
    // the last flag falls at random or never comes, so meshes run together.
    task automatic run_random_mesh(input int max_len);
        vertex_t pool[$];
        vertex_t v;
        int      n_pool;
        int      len;
        int      pick;
        int      bitpos;
        bit      broken;
        bit      last;
        src_calm = ($urandom_range(0, 3) == 0);
        n_pool   = $urandom_range(1, 24);
        repeat (n_pool)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                v = $urandom_range(0, 1) ? '1 : '0;
            else if (pick <= 2 && pool.size() != 0)
            begin
                v         = pool[$urandom_range(0, pool.size() - 1)];
                bitpos    = $urandom_range(0, VTX_W - 1);
                v[bitpos] = ~v[bitpos];
            end
            else
                v = rand_vertex();
            pool.push_back(v);
        end
        // Mostly short meshes; now and then a longer one.
        len    = ($urandom_range(0, 9) < 8) ? 3 * $urandom_range(1, 16)
                                             : $urandom_range(50, 200);
        if (len > max_len)
            len = max_len;
        broken = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++)
        begin
            // Occasional fresh vertex as noise.
            v    = ($urandom_range(0, 9) == 0) ? rand_vertex()
                                               : pool[$urandom_range(0, pool.size() - 1)];
            last = broken ? ($urandom_range(0, 19) == 0) : (i == len - 1);
            send_corner(v, last);
        end
    endtask

    // Result side: random stalls per result, calm stretches, and now and
    // then a long hold so the block backs up and stalls its input.
    initial
    begin
        int gap;
        int results_seen;
        results_seen = 0;
        @(posedge rst_n);
        forever
        begin
            if (results_seen % 40 == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
            if (results_seen % 200 == 100)
                gap = HOLD_CYCLES;
            else
                gap = sink_calm ? 0 : $urandom_range(0, 3);
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            sb.check_reindex(out_data);
            results_seen++;
        end
    end

    initial
    begin
        int      random_base;
        int      drain;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extreme records, hits, single-word differences, last
        // on a hit, on a fresh table and on a new entry.
        send_corner('0, 1'b0);                                  // new, slot 0
        send_corner('1, 1'b0);                                  // new, slot 1
        send_corner('0, 1'b0);                                  // hit slot 0
        send_corner(vertex_t'(1), 1'b0);                        // word0 lsb only
        send_corner({1'b1, {(VTX_W - 1){1'b0}}}, 1'b0);         // word3 msb only
        send_corner(vertex_t'({WORD_W{1'b1}}) << WORD_W, 1'b0);       // word1 only
        send_corner(vertex_t'({WORD_W{1'b1}}) << (2 * WORD_W), 1'b0); // word2 only
        send_corner({1'b0, {(VTX_W - 1){1'b1}}}, 1'b0);         // ones but top bit
        send_corner('1, 1'b0);                                  // hit slot 1
        send_corner({1'b1, {(VTX_W - 1){1'b0}}}, 1'b0);         // hit mid-table
        send_corner('0, 1'b1);                                  // last on a hit
        send_corner('1, 1'b1);                                  // one-corner mesh
        send_corner('1, 1'b0);                                  // new again at slot 0
        send_corner(~vertex_t'(1), 1'b0);                       // ones but lsb
        send_corner(rand_vertex(), 1'b1);                       // last on a new entry

        // Random meshes.
        random_base = corners_sent;
        while (corners_sent - random_base < RANDOM_CORNERS)
            run_random_mesh(RANDOM_CORNERS - (corners_sent - random_base));
        in_valid <= 1'b0;

        // Drain, then let any stray result show up.
        drain = 0;
        while (sb.pending() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** vertex_dedup_reindexer: PASSED **");
        else
        begin
            if (sb.pending() != 0)
                $display("%0d results never arrived", sb.pending());
            $display("** vertex_dedup_reindexer: FAILED **");
        end
        $finish;
    end

endmodule

// ===== vertex_dedup_reindexer.f =====
sv/vdr_pkg.sv
sv/vdr_ctrl.sv
sv/vdr_datapath.sv
sv/vertex_dedup_reindexer.sv
tb/tb.sv
